// File: src/swrt_pkg.sv
package swrt_pkg;

	// Register map
	localparam int ADDR_W = 5;
	localparam int IDX_W = 3;
	localparam int DATA_W = 32;
	localparam int OUT_W = 17;

	localparam logic [IDX_W-1:0] REG_TURN_MODE = 3'd0;
	localparam logic [IDX_W-1:0] REG_SENSITIVITY = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_STEP = 3'd2;
	localparam logic [IDX_W-1:0] REG_MIN_STEP = 3'd3;
	localparam logic [IDX_W-1:0] REG_FLOOR_DEFAULT = 3'd4;
	localparam logic [IDX_W-1:0] REG_FLOOR_TOUCH = 3'd5;

	// Reset values
	localparam logic RST_TURN_MODE = 1'b0;
	localparam logic [7:0] RST_SENSITIVITY = 8'd192;
	localparam logic [15:0] RST_MAX_STEP = 16'd8192;
	localparam logic [15:0] RST_MIN_STEP = 16'd91;
	localparam logic [31:0] RST_FLOOR_DEFAULT = 32'd24159191;
	localparam logic [31:0] RST_FLOOR_TOUCH = 32'd858993459;

	// Half a turn in the 32-bit angle accumulator
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;

	// Largest and smallest result values
	localparam int OUT_MAX = 65535;
	localparam int OUT_MIN = -65536;

	typedef struct packed {
		logic        turn_mode;
		logic [7:0]  sensitivity;
		logic [15:0] max_step;
		logic [15:0] min_step;
		logic [31:0] floor_default;
		logic [31:0] floor_touch;
	} cfg_t;

	// atan(2^-i), 2^32 units per full turn
	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		case (idx)
			5'd0: atan_entry = 32'd536870912;
			5'd1: atan_entry = 32'd316933406;
			5'd2: atan_entry = 32'd167458907;
			5'd3: atan_entry = 32'd85004756;
			5'd4: atan_entry = 32'd42667331;
			5'd5: atan_entry = 32'd21354465;
			5'd6: atan_entry = 32'd10679838;
			5'd7: atan_entry = 32'd5340245;
			5'd8: atan_entry = 32'd2670163;
			5'd9: atan_entry = 32'd1335087;
			5'd10: atan_entry = 32'd667544;
			5'd11: atan_entry = 32'd333772;
			5'd12: atan_entry = 32'd166886;
			5'd13: atan_entry = 32'd83443;
			5'd14: atan_entry = 32'd41722;
			5'd15: atan_entry = 32'd20861;
			5'd16: atan_entry = 32'd10430;
			5'd17: atan_entry = 32'd5215;
			5'd18: atan_entry = 32'd2608;
			5'd19: atan_entry = 32'd1304;
			5'd20: atan_entry = 32'd652;
			5'd21: atan_entry = 32'd326;
			5'd22: atan_entry = 32'd163;
			5'd23: atan_entry = 32'd81;
			default: atan_entry = 32'd0;
		endcase
	endfunction

endpackage

// File: src/swrt_cell.sv
module swrt_cell #(
	parameter int IDX = 0,
	parameter int CW = 27
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	input  logic signed [CW-1:0] up_x,
	input  logic signed [CW-1:0] up_y,
	input  logic [31:0]          up_acc,
	output logic                 dn_valid,
	output logic signed [CW-1:0] dn_x,
	output logic signed [CW-1:0] dn_y,
	output logic [31:0]          dn_acc
);
	import swrt_pkg::*;

	localparam logic [31:0] ATAN = atan_entry(5'(IDX));

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	// Scale the cross terms by this cell's fixed shift
	assign dx = up_y >>> IDX;
	assign dy = up_x >>> IDX;

	// Pass the occupancy flag down the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else begin
			dn_valid <= up_valid;
		end
	end

	// Rotate towards the X axis and accumulate the angle
	always_ff @(posedge clk) begin
		if (up_valid) begin
			if (!up_y[CW-1]) begin
				dn_x <= up_x + dx;
				dn_y <= up_y - dy;
				dn_acc <= up_acc + ATAN;
			end else begin
				dn_x <= up_x - dx;
				dn_y <= up_y + dy;
				dn_acc <= up_acc - ATAN;
			end
		end
	end

endmodule

// File: src/swrt_regs.sv
module swrt_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swrt_pkg::ADDR_W-1:0] paddr,
	input  logic [swrt_pkg::DATA_W-1:0] pwdata,
	output logic [swrt_pkg::DATA_W-1:0] prdata,
	output swrt_pkg::cfg_t              cfg
);
	import swrt_pkg::*;

	logic [IDX_W-1:0] idx;
	logic wr_en;
	cfg_t cfg_q;

	assign idx = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	// Write on the access phase; ignore unmapped addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turn_mode <= RST_TURN_MODE;
			cfg_q.sensitivity <= RST_SENSITIVITY;
			cfg_q.max_step <= RST_MAX_STEP;
			cfg_q.min_step <= RST_MIN_STEP;
			cfg_q.floor_default <= RST_FLOOR_DEFAULT;
			cfg_q.floor_touch <= RST_FLOOR_TOUCH;
		end else if (wr_en) begin
			case (idx)
				REG_TURN_MODE: cfg_q.turn_mode <= pwdata[0];
				REG_SENSITIVITY: cfg_q.sensitivity <= pwdata[7:0];
				REG_MAX_STEP: cfg_q.max_step <= pwdata[15:0];
				REG_MIN_STEP: cfg_q.min_step <= pwdata[15:0];
				REG_FLOOR_DEFAULT: cfg_q.floor_default <= pwdata;
				REG_FLOOR_TOUCH: cfg_q.floor_touch <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_TURN_MODE: prdata = {31'd0, cfg_q.turn_mode};
			REG_SENSITIVITY: prdata = {24'd0, cfg_q.sensitivity};
			REG_MAX_STEP: prdata = {16'd0, cfg_q.max_step};
			REG_MIN_STEP: prdata = {16'd0, cfg_q.min_step};
			REG_FLOOR_DEFAULT: prdata = cfg_q.floor_default;
			REG_FLOOR_TOUCH: prdata = cfg_q.floor_touch;
			default: prdata = '0;
		endcase
	end

endmodule

// File: src/stick_wheel_rotation_tracker_unit.sv
// Stick wheel rotation tracker.
// Input channel: in_valid/in_stall carry one stick sample (stick_x, stick_y,
// touch_type) per transaction. Output channel: out_valid/out_stall carry one
// rotate_value per input transaction, in order.
// In wheel mode the stick angle comes from a row of ANGLE_BITS CORDIC cells;
// the sample steps one cell per cycle, then three stages turn the angle into
// a gated, scaled step. In normal mode the result is stick X, saturated.
// An accepted sample is captured with the start flag, passes the row of cells
// and the three tail stages, and lands in the output register. Only one sample
// is in flight at a time, so a new sample is taken only once the previous one
// has left the tail stages.
// A finished result waits in the output register, with a second holding slot
// behind it; while the receiver stalls a new sample may be taken, and
// in_stall stays high only while both slots are full or a sample is in flight.
// Reset clears the pipeline, the stored previous angle (to zero) and sets all
// configuration registers to their defaults. Registers are written over the APB
// port, by the user only while the block is idle; the block does not enforce it.
module stick_wheel_rotation_tracker_unit #(
	parameter int ANGLE_BITS = 16,
	parameter int AXIS_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [swrt_pkg::ADDR_W-1:0]  paddr,
	input  logic [swrt_pkg::DATA_W-1:0]  pwdata,
	output logic [swrt_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [AXIS_BITS-1:0]  stick_x,
	input  logic signed [AXIS_BITS-1:0]  stick_y,
	input  logic                         touch_type,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [swrt_pkg::OUT_W-1:0] rotate_value
);
	import swrt_pkg::*;

	localparam int CW = AXIS_BITS + 11;
	localparam int SH = 32 - ANGLE_BITS;
	localparam int R2W = 2 * AXIS_BITS;
	localparam int RSL = (R2W < 32) ? 32 - R2W : 0;
	localparam int RSR = (R2W > 32) ? R2W - 32 : 0;
	localparam int R2X = R2W + RSL;
	localparam int PW = ANGLE_BITS + 8;
	localparam logic [31:0] RND = 32'd1 << (SH - 1);

	cfg_t cfg;

	logic in_acc;
	logic out_take;
	logic busy_q;
	logic start_q;
	logic signed [AXIS_BITS-1:0] x_q;
	logic signed [AXIS_BITS-1:0] y_q;
	logic touch_q;
	logic origin;

	logic signed [CW-1:0] xe;
	logic signed [CW-1:0] ye;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic                 fold;

	logic [ANGLE_BITS:0]  cv;
	logic signed [CW-1:0] cx [ANGLE_BITS+1];
	logic signed [CW-1:0] cy [ANGLE_BITS+1];
	logic [31:0]          ca [ANGLE_BITS+1];

	logic [R2W-1:0] xsq_s1;
	logic [R2W-1:0] ysq_s1;
	logic [R2W-1:0] r2;
	logic [R2X-1:0] r2x;
	logic [31:0]    r2_scaled;
	logic           rad_ok_s2;

	logic [31:0]            rsum;
	logic                   v_s1;
	logic [ANGLE_BITS-1:0]  angle_s1;
	logic                   v_s2;
	logic signed [ANGLE_BITS:0] step_s2;
	logic                   zero_s2;
	logic [ANGLE_BITS-1:0]  mag;
	logic                   v_s3;
	logic [ANGLE_BITS-1:0]  mag_s3;
	logic                   neg_s3;
	logic                   rej_s3;
	logic [ANGLE_BITS-1:0]  prev_q;

	logic [PW-1:0]          prod;
	logic [ANGLE_BITS-1:0]  gain;
	logic signed [31:0]     wheel_val;
	logic signed [31:0]     xw;
	logic signed [31:0]     xsat;
	logic [OUT_W-1:0]       res;

	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_q;
	logic                   hold_v_q;
	logic [OUT_W-1:0]       hold_q;

	swrt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// Handshakes
	assign in_stall = busy_q || hold_v_q;
	assign in_acc = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	// Capture the sample; it holds until the next transaction
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= stick_x;
			y_q <= stick_y;
			touch_q <= touch_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= in_acc;
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (v_s3) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign origin = (x_q == '0) && (y_q == '0);

	// Scale by 256 and fold the left half plane onto the right
	always_comb begin
		xe = CW'(x_q);
		ye = CW'(y_q);
		xs = xe <<< 8;
		ys = ye <<< 8;
	end

	assign fold = xs[CW-1];
	assign cv[0] = start_q;
	assign cx[0] = fold ? -xs : xs;
	assign cy[0] = fold ? -ys : ys;
	assign ca[0] = fold ? HALF_TURN : '0;

	// Row of CORDIC cells, one iteration each
	for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_cell
		swrt_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cv[i]),
			.up_x     (cx[i]),
			.up_y     (cy[i]),
			.up_acc   (ca[i]),
			.dn_valid (cv[i+1]),
			.dn_x     (cx[i+1]),
			.dn_y     (cy[i+1]),
			.dn_acc   (ca[i+1])
		);
	end

	// Squared radius in Q2.30; settles long before the angle does
	always_ff @(posedge clk) begin
		xsq_s1 <= R2W'(x_q) * R2W'(x_q);
		ysq_s1 <= R2W'(y_q) * R2W'(y_q);
		rad_ok_s2 <= r2_scaled >= (touch_q ? cfg.floor_touch : cfg.floor_default);
	end

	assign r2 = xsq_s1 + ysq_s1;
	assign r2x = R2X'(r2) << RSL;
	assign r2_scaled = 32'(r2x >> RSR);

	// Round the accumulated angle to ANGLE_BITS
	assign rsum = ca[ANGLE_BITS] + RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			prev_q <= '0;
		end else begin
			v_s1 <= cv[ANGLE_BITS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s1 && !cfg.turn_mode) begin
				prev_q <= angle_s1;
			end
		end
	end

	assign mag = step_s2[ANGLE_BITS] ? ANGLE_BITS'(-step_s2) : ANGLE_BITS'(step_s2);

	// Angle, step against the stored angle, then the gating checks
	always_ff @(posedge clk) begin
		if (cv[ANGLE_BITS]) begin
			angle_s1 <= origin ? '0 : rsum[31:SH];
		end
		if (v_s1) begin
			step_s2 <= $signed({1'b0, prev_q}) - $signed({1'b0, angle_s1});
			zero_s2 <= angle_s1 == '0;
		end
		if (v_s2) begin
			mag_s3 <= mag;
			neg_s3 <= step_s2[ANGLE_BITS];
			rej_s3 <= zero_s2 || (32'(mag) > 32'(cfg.max_step)) ||
				(32'(mag) < 32'(cfg.min_step)) || !rad_ok_s2;
		end
	end

	// Apply the gain, truncating towards zero
	assign prod = PW'(mag_s3) * PW'(cfg.sensitivity);
	assign gain = prod[PW-1:8];

	always_comb begin
		if (rej_s3) begin
			wheel_val = '0;
		end else if (neg_s3) begin
			wheel_val = -$signed(32'(gain));
		end else begin
			wheel_val = $signed(32'(gain));
		end
	end

	// Normal mode: stick X, saturated to the result range
	assign xw = 32'(x_q);

	always_comb begin
		if (xw > OUT_MAX) begin
			xsat = OUT_MAX;
		end else if (xw < OUT_MIN) begin
			xsat = OUT_MIN;
		end else begin
			xsat = xw;
		end
	end

	assign res = cfg.turn_mode ? xsat[OUT_W-1:0] : wheel_val[OUT_W-1:0];

	// Output register with one holding slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_v_q <= 1'b0;
		end else if (v_s3) begin
			out_valid_q <= 1'b1;
			if (out_valid_q && out_stall) begin
				hold_v_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= hold_v_q;
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			if (!out_valid_q || !out_stall) begin
				out_q <= res;
			end else begin
				hold_q <= res;
			end
		end else if (out_take && hold_v_q) begin
			out_q <= hold_q;
		end
	end

	assign out_valid = out_valid_q;
	assign rotate_value = $signed(out_q);

`ifndef SYNTHESIS
	// At most one sample anywhere in the row or the tail stages
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cv, v_s1, v_s2, v_s3}))
		else $error("more than one sample in flight");

	// The holding slot is only used behind a full output register
	a_hold_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> out_valid_q)
		else $error("holding slot full with output register empty");

	// A finishing sample never meets a full holding slot
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> !hold_v_q)
		else $error("result arrived with holding slot full");

	// A sample entering the row marks the block busy
	a_busy_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> busy_q)
		else $error("sample in row while block idle");
`endif

endmodule

// File: sim/stick_wheel_rotation_tracker_unit_test.sv
module stick_wheel_rotation_tracker_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swrt_pkg::*;

	localparam int ANGLE_BITS = 16;
	localparam int AXIS_BITS = 16;
	localparam int GUARD_SCALE = 256;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int PHASE_COUNT = 8;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;

	// Turn modes and the register indexes the block does not decode
	localparam logic TURN_WHEEL = 1'b0;
	localparam logic TURN_PASS_X = 1'b1;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// atan(2^-i), 2^32 units per full turn
	localparam logic [31:0] ARCTAN_TURN [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	localparam logic signed [AXIS_BITS-1:0] AXIS_CORNERS [5] = '{
		16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001
	};

	typedef struct packed {
		logic                        mode;
		logic signed [AXIS_BITS-1:0] x;
		logic signed [AXIS_BITS-1:0] y;
		logic                        touch;
		logic                        typed;
		logic signed [OUT_W-1:0]     want;
	} probe_t;

	// Directed samples; a typed result is used where it is obvious
	localparam probe_t PROBES [24] = '{
		'{TURN_WHEEL, 16'sd0, 16'sd0, 1'b0, 1'b1, 17'sd0},
		'{TURN_WHEEL, 16'sd32767, 16'sd0, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd0, 16'sd32767, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'h8000, 16'sd0, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd0, 16'h8000, 1'b1, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'h8000, 16'h8000, 1'b1, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'h8000, 16'sd32767, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd32767, 16'h8000, 1'b1, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd100, -16'sd100, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd16384, 16'sd16384, 1'b1, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd23170, 16'sd23170, 1'b1, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd21213, 16'sd21213, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd21114, 16'sd21312, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd16665, 16'sd24945, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, -16'sd5310, 16'sd29526, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd3291, 16'sd29819, 1'b1, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'sd0, 16'sd0, 1'b1, 1'b1, 17'sd0},
		'{TURN_PASS_X, 16'sd32767, 16'sd5, 1'b0, 1'b1, 17'sd32767},
		'{TURN_PASS_X, 16'h8000, -16'sd7, 1'b1, 1'b1, -17'sd32768},
		'{TURN_PASS_X, 16'sd0, 16'sd0, 1'b0, 1'b1, 17'sd0},
		'{TURN_PASS_X, -16'sd1, 16'sd32767, 1'b1, 1'b1, -17'sd1},
		'{TURN_WHEEL, 16'sd1, 16'sd0, 1'b0, 1'b0, 17'sd0},
		'{TURN_WHEEL, 16'h8000, -16'sd1, 1'b0, 1'b0, 17'sd0}
	};

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [ADDR_W-1:0]           paddr;
	logic [DATA_W-1:0]           pwdata;
	logic [DATA_W-1:0]           prdata;
	logic                        pready;
	logic                        in_valid;
	logic                        in_stall;
	logic signed [AXIS_BITS-1:0] stick_x;
	logic signed [AXIS_BITS-1:0] stick_y;
	logic                        touch_type;
	logic                        out_valid;
	logic                        out_stall;
	logic signed [OUT_W-1:0]     rotate_value;

	// Predictor state and the results still owed by the block
	cfg_t                        tracker_cfg;
	logic [ANGLE_BITS-1:0]       last_angle;
	logic signed [OUT_W-1:0]     pending_rotation [$];
	logic signed [OUT_W-1:0]     oldest_rotation;
	int                          mismatch_count = 0;
	int                          quiet_cycles = 0;
	int                          burst_left = 0;
	int                          gesture_heading = 0;
	bit                          hold_off_req = 1'b0;
	bit                          hold_off_done = 1'b0;

	stick_wheel_rotation_tracker_unit #(
		.ANGLE_BITS(ANGLE_BITS),
		.AXIS_BITS(AXIS_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stick_x(stick_x),
		.stick_y(stick_y),
		.touch_type(touch_type),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rotate_value(rotate_value)
	);

	always #5 clk = ~clk;

	// Binary angle of the stick by CORDIC vectoring, rounded half up
	function automatic logic [ANGLE_BITS-1:0] stick_heading(input longint x, input longint y);
		longint cx;
		longint cy;
		longint dx;
		longint dy;
		logic [31:0] acc;
		int i;
		if (x == 0 && y == 0)
			return '0;
		acc = '0;
		cx = x * GUARD_SCALE;
		cy = y * GUARD_SCALE;
		// fold the left half-plane over
		if (cx < 0) begin
			cx = -cx;
			cy = -cy;
			acc = HALF_TURN;
		end
		for (i = 0; i < ANGLE_BITS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx += dx;
				cy -= dy;
				acc += ARCTAN_TURN[i];
			end else begin
				cx -= dx;
				cy += dy;
				acc -= ARCTAN_TURN[i];
			end
		end
		acc += 32'd1 << (31 - ANGLE_BITS);
		return acc[31 -: ANGLE_BITS];
	endfunction

	// Rotation caused by one sample; advances the stored angle in wheel mode
	function automatic logic signed [OUT_W-1:0] rotation_of_sample(
		input logic signed [AXIS_BITS-1:0] sx,
		input logic signed [AXIS_BITS-1:0] sy,
		input logic st
	);
		longint x;
		longint y;
		longint prev;
		longint now;
		longint step;
		longint mag;
		longint r2;
		longint floor_sq;
		longint max_mag;
		longint min_mag;
		longint gain;
		longint scaled;
		logic [ANGLE_BITS-1:0] heading;
		x = sx;
		y = sy;
		if (tracker_cfg.turn_mode == TURN_PASS_X)
			return OUT_W'(x);
		heading = stick_heading(x, y);
		prev = last_angle;
		now = heading;
		step = prev - now;
		mag = (step < 0) ? -step : step;
		// Q1.15 squared sums are already Q2.30
		r2 = x * x + y * y;
		floor_sq = st ? tracker_cfg.floor_touch : tracker_cfg.floor_default;
		max_mag = tracker_cfg.max_step;
		min_mag = tracker_cfg.min_step;
		gain = tracker_cfg.sensitivity;
		last_angle = heading;
		if (now == 0 || mag > max_mag || mag < min_mag || r2 < floor_sq)
			return '0;
		scaled = (mag * gain) >> 8;
		return OUT_W'((step < 0) ? -scaled : scaled);
	endfunction

	function automatic logic [DATA_W-1:0] reg_image(input logic [IDX_W-1:0] idx);
		case (idx)
			REG_TURN_MODE:     return {31'd0, tracker_cfg.turn_mode};
			REG_SENSITIVITY:   return {24'd0, tracker_cfg.sensitivity};
			REG_MAX_STEP:      return {16'd0, tracker_cfg.max_step};
			REG_MIN_STEP:      return {16'd0, tracker_cfg.min_step};
			REG_FLOOR_DEFAULT: return tracker_cfg.floor_default;
			REG_FLOOR_TOUCH:   return tracker_cfg.floor_touch;
			default:           return '0;
		endcase
	endfunction

	// One APB transfer: setup, access, then an idle cycle
	task automatic apb_transfer(input logic [IDX_W-1:0] idx, input logic wr,
		input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic [IDX_W-1:0] idx);
		logic [DATA_W-1:0] rd;
		apb_transfer(idx, 1'b0, '0, rd);
		if (rd !== reg_image(idx)) begin
			$error("register %0d: expected %0h, got %0h", idx, reg_image(idx), rd);
			mismatch_count++;
		end
	endtask

	// Write a register, mask it into the shadow copy and read it back if it is mapped
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] unused;
		apb_transfer(idx, 1'b1, value, unused);
		case (idx)
			REG_TURN_MODE:     tracker_cfg.turn_mode = value[0];
			REG_SENSITIVITY:   tracker_cfg.sensitivity = value[7:0];
			REG_MAX_STEP:      tracker_cfg.max_step = value[15:0];
			REG_MIN_STEP:      tracker_cfg.min_step = value[15:0];
			REG_FLOOR_DEFAULT: tracker_cfg.floor_default = value;
			REG_FLOOR_TOUCH:   tracker_cfg.floor_touch = value;
			default: ;
		endcase
		if (idx <= REG_FLOOR_TOUCH)
			check_register(idx);
	endtask

	// Program every register; junk fills the bits above each register's width
	task automatic program_setting(input logic mode, input logic [7:0] sens,
		input logic [15:0] max_s, input logic [15:0] min_s,
		input logic [31:0] floor_d, input logic [31:0] floor_t, input logic [31:0] junk);
		write_reg(REG_TURN_MODE, {junk[31:1], mode});
		write_reg(REG_SENSITIVITY, {junk[31:8], sens});
		write_reg(REG_MAX_STEP, {junk[31:16], max_s});
		write_reg(REG_MIN_STEP, {junk[31:16], min_s});
		write_reg(REG_FLOOR_DEFAULT, floor_d);
		write_reg(REG_FLOOR_TOUCH, floor_t);
	endtask

	// Drop valid and wait for every owed result
	task automatic settle_pipeline();
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_rotation.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// End a burst now and then with a random gap
	task automatic pace_sender();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Offer one sample, hold it until taken and record the owed result
	task automatic send_sample(input logic signed [AXIS_BITS-1:0] sx,
		input logic signed [AXIS_BITS-1:0] sy, input logic st,
		input logic typed, input logic signed [OUT_W-1:0] want);
		logic signed [OUT_W-1:0] predicted;
		in_valid <= 1'b1;
		stick_x <= sx;
		stick_y <= sy;
		touch_type <= st;
		do @(posedge clk); while (in_stall);
		predicted = rotation_of_sample(sx, sy, st);
		pending_rotation.push_back(typed ? want : predicted);
		pace_sender();
	endtask

	// Mostly smooth turning gestures, with noise, near-centre and corner samples
	task automatic next_sample(output logic signed [AXIS_BITS-1:0] sx,
		output logic signed [AXIS_BITS-1:0] sy, output logic st);
		int kind;
		int delta;
		int radius;
		int ox;
		int oy;
		real ang;
		kind = $urandom_range(0, 99);
		st = 1'($urandom_range(0, 1));
		if (kind < 70) begin
			case ($urandom_range(0, 3))
				0: delta = $urandom_range(0, 120);
				1: delta = $urandom_range(80, 2000);
				2: delta = $urandom_range(2000, 9000);
				default: delta = $urandom_range(9000, 40000);
			endcase
			if ($urandom_range(0, 1))
				delta = -delta;
			gesture_heading = (gesture_heading + delta) & 32'hFFFF;
			radius = $urandom_range(2000, 32767);
			ang = 6.283185307179586 * gesture_heading / 65536.0;
			sx = AXIS_BITS'($rtoi(radius * $cos(ang)));
			sy = AXIS_BITS'($rtoi(radius * $sin(ang)));
		end else if (kind < 85) begin
			sx = AXIS_BITS'($urandom);
			sy = AXIS_BITS'($urandom);
		end else if (kind < 93) begin
			ox = $urandom_range(0, 400);
			oy = $urandom_range(0, 400);
			if ($urandom_range(0, 4) == 0) begin
				ox = 200;
				oy = 200;
			end
			sx = AXIS_BITS'(ox - 200);
			sy = AXIS_BITS'(oy - 200);
		end else begin
			sx = AXIS_CORNERS[$urandom_range(0, 4)];
			sy = AXIS_CORNERS[$urandom_range(0, 4)];
		end
	endtask

	// Stall pattern of the receiver, with one long hold-off on request
	initial begin : receiver
		int seg;
		int len;
		int k;
		out_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_off_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				seg = $urandom_range(0, 3);
				len = $urandom_range(8, 60);
				for (k = 0; k < len; k++) begin
					case (seg)
						0: out_stall <= 1'b0;
						1: out_stall <= 1'($urandom_range(0, 1));
						2: out_stall <= ((k % 4) == 3);
						default: out_stall <= ($urandom_range(0, 9) < 8);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Compare each result transaction with the oldest owed result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rotation.size() == 0) begin
				$error("rotate_value %0d arrived with nothing outstanding", rotate_value);
				mismatch_count++;
			end else begin
				oldest_rotation = pending_rotation.pop_front();
				if (rotate_value !== oldest_rotation) begin
					$error("rotate_value: expected %0d, got %0d", oldest_rotation, rotate_value);
					mismatch_count++;
				end
			end
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		int ph;
		int n;
		logic signed [AXIS_BITS-1:0] sx;
		logic signed [AXIS_BITS-1:0] sy;
		logic st;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		stick_x = '0;
		stick_y = '0;
		touch_type = 1'b0;
		tracker_cfg = '{RST_TURN_MODE, RST_SENSITIVITY, RST_MAX_STEP, RST_MIN_STEP,
			RST_FLOOR_DEFAULT, RST_FLOOR_TOUCH};
		last_angle = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, then writes the block must ignore
		for (i = 0; i <= REG_FLOOR_TOUCH; i++)
			check_register(i[IDX_W-1:0]);
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);

		// directed samples
		for (i = 0; i < $size(PROBES); i++) begin
			if (PROBES[i].mode != tracker_cfg.turn_mode) begin
				settle_pipeline();
				write_reg(REG_TURN_MODE, {31'd0, PROBES[i].mode});
			end
			send_sample(PROBES[i].x, PROBES[i].y, PROBES[i].touch, PROBES[i].typed,
				PROBES[i].want);
		end
		settle_pipeline();

		// random phases, each under its own register setting
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: program_setting(TURN_WHEEL, RST_SENSITIVITY, RST_MAX_STEP, RST_MIN_STEP,
					RST_FLOOR_DEFAULT, RST_FLOOR_TOUCH, '0);
				1: program_setting(TURN_WHEEL, 8'hFF, 16'hFFFF, 16'h0000, '0, '0, '0);
				2: program_setting(TURN_WHEEL, 8'h00, 16'($urandom),
					16'($urandom_range(0, 500)), $urandom_range(0, 32'h3FFF_FFFF),
					$urandom, '0);
				3: program_setting(TURN_WHEEL, 8'h80, 16'h0000, 16'h0000, RST_FLOOR_DEFAULT,
					'0, '0);
				4: program_setting(TURN_WHEEL, 8'($urandom_range(1, 255)), 16'hFFFF, 16'hFFFF,
					32'h8000_0000, 32'hFFFF_FFFF, '0);
				5: program_setting(TURN_PASS_X, 8'($urandom), 16'($urandom), 16'($urandom),
					$urandom, $urandom, $urandom);
				6: program_setting(TURN_WHEEL, 8'($urandom), 16'($urandom), 16'($urandom),
					$urandom, $urandom, $urandom);
				default: program_setting(TURN_WHEEL, 8'($urandom),
					16'($urandom_range(2000, 30000)), 16'($urandom_range(0, 600)),
					$urandom_range(0, 32'h4000_0000), $urandom_range(0, 32'h4000_0000),
					$urandom);
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// fill the block behind a long hold-off once
				if (ph == 1 && n == 40)
					hold_off_req = 1'b1;
				// let the block empty completely once mid-stream
				if (ph == 2 && n == 60)
					settle_pipeline();
				next_sample(sx, sy, st);
				send_sample(sx, sy, st, 1'b0, '0);
			end
			settle_pipeline();
		end

		// catch any stray result transaction
		repeat (ANGLE_BITS + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/swrt_pkg.sv
src/swrt_cell.sv
src/swrt_regs.sv
src/stick_wheel_rotation_tracker_unit.sv
sim/stick_wheel_rotation_tracker_unit_test.sv
